// ===== hw/rtl/classifier_status_lock_filter_core_macros.svh =====
// assertion helpers for the rtl filter core
`ifndef CLASSIFIER_STATUS_LOCK_FILTER_CORE_MACROS_SVH
`define CLASSIFIER_STATUS_LOCK_FILTER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define SLF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/slf_pkg.sv =====
// ----------------------------------------------------------------------------
// slf_pkg
// Shared types and constants of the status lock filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slf_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // class codes
  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_MASK    = 2'd1;
  localparam logic [1:0] CLS_NOMASK  = 2'd2;

  localparam logic [7:0] RUN_MAX = 8'd255;

  // register indexes
  localparam logic [2:0] REG_ESTABLISH_RUN     = 3'd0;
  localparam logic [2:0] REG_QUICK_RELEASE_RUN = 3'd1;
  localparam logic [2:0] REG_RELOCK_RUN        = 3'd2;
  localparam logic [2:0] REG_HOLD_MASK_FRAMES  = 3'd3;
  localparam logic [2:0] REG_HOLD_OTHER_FRAMES = 3'd4;
  localparam logic [2:0] REG_EXTEND_FRAMES     = 3'd5;
  localparam logic [2:0] REG_QUICK_HOLD_FRAMES = 3'd6;

  // register reset values
  localparam logic [7:0] RST_ESTABLISH_RUN     = 8'd5;
  localparam logic [7:0] RST_QUICK_RELEASE_RUN = 8'd8;
  localparam logic [7:0] RST_RELOCK_RUN        = 8'd12;
  localparam logic [7:0] RST_HOLD_MASK_FRAMES  = 8'd90;
  localparam logic [7:0] RST_HOLD_OTHER_FRAMES = 8'd60;
  localparam logic [7:0] RST_EXTEND_FRAMES     = 8'd20;
  localparam logic [7:0] RST_QUICK_HOLD_FRAMES = 8'd60;

  typedef struct packed {
    logic [7:0] establish_run;
    logic [7:0] quick_release_run;
    logic [7:0] relock_run;
    logic [7:0] hold_mask_frames;
    logic [7:0] hold_other_frames;
    logic [7:0] extend_frames;
    logic [7:0] quick_hold_frames;
  } cfg_t;

endpackage

// ===== hw/rtl/slf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slf_cfg_regs
// APB-style register file holding the thresholds and hold durations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slf_pkg::ADDR_W-1:0]  paddr,
  input  logic [slf_pkg::DATA_W-1:0]  pwdata,
  output logic [slf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output slf_pkg::cfg_t               cfg
);

  logic [2:0] index;
  logic       wr_en;
  logic [7:0] wdata;
  logic [7:0] rdata;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wdata  = pwdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.establish_run     <= slf_pkg::RST_ESTABLISH_RUN;
      cfg.quick_release_run <= slf_pkg::RST_QUICK_RELEASE_RUN;
      cfg.relock_run        <= slf_pkg::RST_RELOCK_RUN;
      cfg.hold_mask_frames  <= slf_pkg::RST_HOLD_MASK_FRAMES;
      cfg.hold_other_frames <= slf_pkg::RST_HOLD_OTHER_FRAMES;
      cfg.extend_frames     <= slf_pkg::RST_EXTEND_FRAMES;
      cfg.quick_hold_frames <= slf_pkg::RST_QUICK_HOLD_FRAMES;
    end else if (wr_en) begin
      unique case (index)
        slf_pkg::REG_ESTABLISH_RUN:     cfg.establish_run     <= wdata;
        slf_pkg::REG_QUICK_RELEASE_RUN: cfg.quick_release_run <= wdata;
        slf_pkg::REG_RELOCK_RUN:        cfg.relock_run        <= wdata;
        slf_pkg::REG_HOLD_MASK_FRAMES:  cfg.hold_mask_frames  <= wdata;
        slf_pkg::REG_HOLD_OTHER_FRAMES: cfg.hold_other_frames <= wdata;
        slf_pkg::REG_EXTEND_FRAMES:     cfg.extend_frames     <= wdata;
        slf_pkg::REG_QUICK_HOLD_FRAMES: cfg.quick_hold_frames <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      slf_pkg::REG_ESTABLISH_RUN:     rdata = cfg.establish_run;
      slf_pkg::REG_QUICK_RELEASE_RUN: rdata = cfg.quick_release_run;
      slf_pkg::REG_RELOCK_RUN:        rdata = cfg.relock_run;
      slf_pkg::REG_HOLD_MASK_FRAMES:  rdata = cfg.hold_mask_frames;
      slf_pkg::REG_HOLD_OTHER_FRAMES: rdata = cfg.hold_other_frames;
      slf_pkg::REG_EXTEND_FRAMES:     rdata = cfg.extend_frames;
      slf_pkg::REG_QUICK_HOLD_FRAMES: rdata = cfg.quick_hold_frames;
      default:                        rdata = 8'd0;
    endcase
  end

  assign prdata = {{(slf_pkg::DATA_W-8){1'b0}}, rdata};

endmodule

// ===== hw/rtl/classifier_status_lock_filter_core.sv =====
// ----------------------------------------------------------------------------
// classifier_status_lock_filter_core
// Smooths a stream of per-frame classes with a run counter and a class lock.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// input    | in        | in_valid / in_stall  | raw_class (2 bit)
// output   | out       | out_valid / out_stall| smooth_class (2 bit)
// config   | in        | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one item per cycle while in_stall is low; its result reaches the output
// register in the cycle after it is taken, set by the run/lock state update.
// rst (synchronous) clears run, lock and fallback state and loads the
// register defaults; no clearing pass is needed.
// in_stall is high only while a result waits in the output register and
// out_stall is high; a result taken in the same cycle frees room for an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "classifier_status_lock_filter_core_macros.svh"

module classifier_status_lock_filter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  raw_class,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  smooth_class,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slf_pkg::ADDR_W-1:0]  paddr,
  input  logic [slf_pkg::DATA_W-1:0]  pwdata,
  output logic [slf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  slf_pkg::cfg_t cfg;

  logic       started;
  logic [1:0] fallback_class;
  logic [1:0] last_raw;
  logic [7:0] run_length;
  logic [1:0] lock_class;
  logic [7:0] lock_left;

  logic       started_next;
  logic [1:0] fallback_class_next;
  logic [7:0] run_length_next;
  logic [1:0] lock_class_next;
  logic [7:0] lock_left_next;
  logic [1:0] result;

  logic       accept;
  logic [7:0] left_dec;
  logic [7:0] hold_raw;
  logic [1:0] fallback_res;

  slf_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign left_dec     = (lock_left != 8'd0) ? lock_left - 8'd1 : 8'd0;
  assign hold_raw     = (raw_class == slf_pkg::CLS_MASK) ? cfg.hold_mask_frames
                                                         : cfg.hold_other_frames;
  assign fallback_res = (fallback_class != slf_pkg::CLS_UNKNOWN) ? fallback_class
                                                                 : raw_class;

  always_comb begin
    started_next        = started;
    fallback_class_next = fallback_class;
    run_length_next     = run_length;
    lock_class_next     = lock_class;
    lock_left_next      = lock_left;
    result              = raw_class;

    if (!started) begin
      // first item passes through and becomes the fallback
      started_next        = 1'b1;
      fallback_class_next = raw_class;
    end else begin
      if (raw_class == last_raw) begin
        if (run_length != slf_pkg::RUN_MAX) begin
          run_length_next = run_length + 8'd1;
        end
      end else begin
        run_length_next = 8'd1;
      end

      result = fallback_res;
      if (lock_class != slf_pkg::CLS_UNKNOWN) begin
        lock_left_next = left_dec;
        if (left_dec != 8'd0) begin
          result = lock_class;
          // long no-mask run breaks a mask lock early
          if (lock_class == slf_pkg::CLS_MASK && raw_class == slf_pkg::CLS_NOMASK &&
              run_length_next >= cfg.quick_release_run) begin
            lock_class_next = raw_class;
            lock_left_next  = cfg.quick_hold_frames;
            result          = raw_class;
          end
        end else if (run_length_next >= cfg.relock_run && raw_class != lock_class) begin
          lock_class_next = raw_class;
          lock_left_next  = hold_raw;
          result          = raw_class;
        end else if (run_length_next < cfg.relock_run) begin
          lock_left_next = cfg.extend_frames;
          result         = lock_class;
        end
      end else if (run_length_next >= cfg.establish_run) begin
        lock_class_next = raw_class;
        lock_left_next  = hold_raw;
        result          = raw_class;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      fallback_class <= slf_pkg::CLS_UNKNOWN;
      last_raw       <= slf_pkg::CLS_UNKNOWN;
      run_length     <= 8'd0;
      lock_class     <= slf_pkg::CLS_UNKNOWN;
      lock_left      <= 8'd0;
    end else if (accept) begin
      started        <= started_next;
      fallback_class <= fallback_class_next;
      if (started) begin
        last_raw <= raw_class;
      end
      run_length <= run_length_next;
      lock_class <= lock_class_next;
      lock_left  <= lock_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smooth_class <= result;
    end
  end

  `SLF_ASSERT_NEXT(a_first_item_passes, accept && !started,
                   out_valid && smooth_class == $past(raw_class),
                   "first item did not pass through")
  `SLF_ASSERT(a_no_lock_before_start,
              !started |-> (lock_class == slf_pkg::CLS_UNKNOWN && run_length == 8'd0),
              "lock or run state moved before the first item")
  `SLF_ASSERT_NEXT(a_run_counts_up,
                   accept && started && raw_class == last_raw &&
                   run_length != slf_pkg::RUN_MAX,
                   run_length == $past(run_length) + 8'd1,
                   "run counter did not advance on a repeated class")
  `SLF_ASSERT_NEXT(a_state_holds_idle, !accept,
                   $stable(lock_class) && $stable(lock_left) && $stable(run_length),
                   "filter state changed without an item")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the status lock filter against an in-bench model of its run counter,
// lock and fallback rules, with random gaps, output stalls and a long hold-off
// across default, extreme and random register settings.
// ----------------------------------------------------------------------------

module tb_top;

  localparam logic [1:0] CLS_INCORRECT = 2'd3;
  localparam logic [2:0] REG_UNUSED    = 3'd7;
  localparam int         CLK_HALF      = 6;
  localparam int         HOLDOFF_CYCLES = 60;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [1:0]                 raw_class = slf_pkg::CLS_UNKNOWN;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 smooth_class;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [slf_pkg::ADDR_W-1:0] paddr     = '0;
  logic [slf_pkg::DATA_W-1:0] pwdata    = '0;
  logic [slf_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  classifier_status_lock_filter_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_class    (raw_class),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .smooth_class (smooth_class),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // model of the filter state
  slf_pkg::cfg_t lock_cfg;
  logic       seen_first   = 1'b0;
  logic [1:0] fallback_cls = slf_pkg::CLS_UNKNOWN;
  logic [1:0] prev_raw     = slf_pkg::CLS_UNKNOWN;
  logic [7:0] run_len      = '0;
  logic [1:0] lock_cls     = slf_pkg::CLS_UNKNOWN;
  logic [7:0] lock_left    = '0;

  logic [1:0] smooth_due[$];
  logic [1:0] due_cls;

  int             items_sent      = 0;
  int             results_checked = 0;
  int             fail_count      = 0;
  int             settings_used   = 0;
  int             burst_left      = 0;
  bit             back_to_back    = 1'b0;
  int             holdoff_left    = 0;
  int             mode_left       = 0;
  stall_pattern_t stall_mode      = STALL_NONE;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** classifier_status_lock_filter_core: FAILED **");
    $finish;
  end

  function automatic slf_pkg::cfg_t default_settings();
    slf_pkg::cfg_t s;
    s.establish_run     = slf_pkg::RST_ESTABLISH_RUN;
    s.quick_release_run = slf_pkg::RST_QUICK_RELEASE_RUN;
    s.relock_run        = slf_pkg::RST_RELOCK_RUN;
    s.hold_mask_frames  = slf_pkg::RST_HOLD_MASK_FRAMES;
    s.hold_other_frames = slf_pkg::RST_HOLD_OTHER_FRAMES;
    s.extend_frames     = slf_pkg::RST_EXTEND_FRAMES;
    s.quick_hold_frames = slf_pkg::RST_QUICK_HOLD_FRAMES;
    return s;
  endfunction

  function automatic logic [7:0] pick_setting(input int span);
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd255;
      default: return 8'($urandom_range(1, span));
    endcase
  endfunction

  function automatic logic [1:0] predict_smooth_class(input logic [1:0] raw);
    if (!seen_first) begin
      seen_first   = 1'b1;
      fallback_cls = raw;
      return raw;
    end
    if (raw == prev_raw) begin
      if (run_len < slf_pkg::RUN_MAX) run_len++;
    end else begin
      run_len  = 8'd1;
      prev_raw = raw;
    end
    if (lock_cls != slf_pkg::CLS_UNKNOWN) begin
      if (lock_left > 0) lock_left--;
      if (lock_left > 0) begin
        // a long enough no-mask run breaks a mask lock early
        if (lock_cls == slf_pkg::CLS_MASK && raw == slf_pkg::CLS_NOMASK &&
            run_len >= lock_cfg.quick_release_run) begin
          lock_cls  = raw;
          lock_left = lock_cfg.quick_hold_frames;
        end
        return lock_cls;
      end
      if (run_len >= lock_cfg.relock_run && raw != lock_cls) begin
        lock_left = (raw == slf_pkg::CLS_MASK) ? lock_cfg.hold_mask_frames
                                               : lock_cfg.hold_other_frames;
        lock_cls  = raw;
        return lock_cls;
      end
      if (run_len < lock_cfg.relock_run) begin
        lock_left = lock_cfg.extend_frames;
        return lock_cls;
      end
      // expired with a long run of the locked class: fall through
    end else if (run_len >= lock_cfg.establish_run) begin
      lock_left = (raw == slf_pkg::CLS_MASK) ? lock_cfg.hold_mask_frames
                                             : lock_cfg.hold_other_frames;
      lock_cls  = raw;
      return lock_cls;
    end
    return (fallback_cls != slf_pkg::CLS_UNKNOWN) ? fallback_cls : raw;
  endfunction

  task automatic write_register(input logic [2:0] idx,
                                input logic [slf_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= slf_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      slf_pkg::REG_ESTABLISH_RUN:     lock_cfg.establish_run     = value[7:0];
      slf_pkg::REG_QUICK_RELEASE_RUN: lock_cfg.quick_release_run = value[7:0];
      slf_pkg::REG_RELOCK_RUN:        lock_cfg.relock_run        = value[7:0];
      slf_pkg::REG_HOLD_MASK_FRAMES:  lock_cfg.hold_mask_frames  = value[7:0];
      slf_pkg::REG_HOLD_OTHER_FRAMES: lock_cfg.hold_other_frames = value[7:0];
      slf_pkg::REG_EXTEND_FRAMES:     lock_cfg.extend_frames     = value[7:0];
      slf_pkg::REG_QUICK_HOLD_FRAMES: lock_cfg.quick_hold_frames = value[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] idx);
    logic [7:0]                 want;
    logic [slf_pkg::DATA_W-1:0] got;
    case (idx)
      slf_pkg::REG_ESTABLISH_RUN:     want = lock_cfg.establish_run;
      slf_pkg::REG_QUICK_RELEASE_RUN: want = lock_cfg.quick_release_run;
      slf_pkg::REG_RELOCK_RUN:        want = lock_cfg.relock_run;
      slf_pkg::REG_HOLD_MASK_FRAMES:  want = lock_cfg.hold_mask_frames;
      slf_pkg::REG_HOLD_OTHER_FRAMES: want = lock_cfg.hold_other_frames;
      slf_pkg::REG_EXTEND_FRAMES:     want = lock_cfg.extend_frames;
      default:                        want = lock_cfg.quick_hold_frames;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= slf_pkg::ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== slf_pkg::DATA_W'(want)) begin
      $error("prdata mismatch at register %0d: expected %0d, got %0d", idx, want, got);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input slf_pkg::cfg_t s);
    write_register(slf_pkg::REG_ESTABLISH_RUN,     slf_pkg::DATA_W'(s.establish_run));
    write_register(slf_pkg::REG_QUICK_RELEASE_RUN, slf_pkg::DATA_W'(s.quick_release_run));
    write_register(slf_pkg::REG_RELOCK_RUN,        slf_pkg::DATA_W'(s.relock_run));
    write_register(slf_pkg::REG_HOLD_MASK_FRAMES,  slf_pkg::DATA_W'(s.hold_mask_frames));
    write_register(slf_pkg::REG_HOLD_OTHER_FRAMES, slf_pkg::DATA_W'(s.hold_other_frames));
    write_register(slf_pkg::REG_EXTEND_FRAMES,     slf_pkg::DATA_W'(s.extend_frames));
    write_register(slf_pkg::REG_QUICK_HOLD_FRAMES, slf_pkg::DATA_W'(s.quick_hold_frames));
    for (int i = slf_pkg::REG_ESTABLISH_RUN; i <= slf_pkg::REG_QUICK_HOLD_FRAMES; i++)
      check_register(3'(i));
    settings_used++;
  endtask

  task automatic send_class(input logic [1:0] cls);
    int gap;
    if (!back_to_back) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid  <= 1'b1;
    raw_class <= cls;
    do @(posedge clk); while (in_stall);
    smooth_due.push_back(predict_smooth_class(cls));
    items_sent++;
  endtask

  // runs of one class with random length; half draw mask or no mask, the rest any class
  task automatic send_runs(input int count, input int span);
    logic [1:0] cls;
    int         len;
    int         left;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 1) == 0)
        cls = ($urandom_range(0, 1) == 0) ? slf_pkg::CLS_MASK : slf_pkg::CLS_NOMASK;
      else
        cls = 2'($urandom_range(0, 3));
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, span);
      if (len > left) len = left;
      repeat (len) send_class(cls);
      left -= len;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (smooth_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_directed_defaults();
    // first class seen becomes the fallback
    send_class(2'($urandom_range(0, 3)));
    send_class(slf_pkg::CLS_UNKNOWN);
    send_class(slf_pkg::CLS_MASK);
    send_class(slf_pkg::CLS_NOMASK);
    send_class(CLS_INCORRECT);
    repeat (5) send_class(slf_pkg::CLS_MASK);
    repeat (8) send_class(slf_pkg::CLS_NOMASK);
    repeat (2) send_class(CLS_INCORRECT);
    wait_idle();
  endtask

  task automatic test_register_access();
    slf_pkg::cfg_t s;
    s.establish_run     = pick_setting(255);
    s.quick_release_run = pick_setting(255);
    s.relock_run        = pick_setting(255);
    s.hold_mask_frames  = pick_setting(255);
    s.hold_other_frames = pick_setting(255);
    s.extend_frames     = pick_setting(255);
    s.quick_hold_frames = pick_setting(255);
    apply_settings(s);
    // a write past the last register must leave all of them alone
    write_register(REG_UNUSED, slf_pkg::DATA_W'($urandom));
    for (int i = slf_pkg::REG_ESTABLISH_RUN; i <= slf_pkg::REG_QUICK_HOLD_FRAMES; i++)
      check_register(3'(i));
  endtask

  task automatic test_quick_release();
    slf_pkg::cfg_t s;
    s.establish_run     = 8'd3;
    s.quick_release_run = 8'd4;
    s.relock_run        = 8'd6;
    s.hold_mask_frames  = 8'd20;
    s.hold_other_frames = 8'd8;
    s.extend_frames     = 8'd3;
    s.quick_hold_frames = 8'd5;
    apply_settings(s);
    repeat (8) begin
      repeat ($urandom_range(3, 5)) send_class(slf_pkg::CLS_MASK);
      repeat ($urandom_range(2, 7)) send_class(slf_pkg::CLS_NOMASK);
    end
    send_runs(60, 8);
    wait_idle();
  endtask

  task automatic test_low_extremes();
    slf_pkg::cfg_t s;
    s = '0;
    s.establish_run     = 8'd1;
    s.quick_release_run = 8'd1;
    s.relock_run        = 8'd1;
    s.hold_mask_frames  = 8'd1;
    s.hold_other_frames = 8'd1;
    s.extend_frames     = 8'd1;
    s.quick_hold_frames = 8'd1;
    apply_settings(s);
    send_runs(120, 4);
    wait_idle();
  endtask

  task automatic test_high_extremes();
    slf_pkg::cfg_t s;
    s = '1;
    apply_settings(s);
    // long enough for the run counter to saturate and the lock to run out
    repeat (258) send_class(slf_pkg::CLS_MASK);
    repeat (256) send_class(slf_pkg::CLS_NOMASK);
    send_runs(20, 4);
    wait_idle();
  endtask

  task automatic test_random_settings();
    slf_pkg::cfg_t s;
    repeat (4) begin
      s.establish_run     = pick_setting(10);
      s.quick_release_run = pick_setting(10);
      s.relock_run        = pick_setting(14);
      s.hold_mask_frames  = pick_setting(24);
      s.hold_other_frames = pick_setting(20);
      s.extend_frames     = pick_setting(10);
      s.quick_hold_frames = pick_setting(16);
      apply_settings(s);
      send_runs(100, 16);
      wait_idle();
    end
  endtask

  task automatic test_output_holdoff();
    apply_settings(default_settings());
    back_to_back = 1'b1;
    holdoff_left = HOLDOFF_CYCLES;
    send_runs(40, 8);
    back_to_back = 1'b0;
    wait_idle();
  endtask

  // receiver: stall pattern changes every so often, or a long hold-off
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_pattern_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (smooth_due.size() == 0) begin
        $error("smooth_class %0d arrived with no item outstanding", smooth_class);
        fail_count++;
      end else begin
        due_cls = smooth_due.pop_front();
        results_checked++;
        if (smooth_class !== due_cls) begin
          $error("smooth_class mismatch: expected %0d, got %0d", due_cls, smooth_class);
          fail_count++;
        end
      end
    end
  end

  initial begin
    lock_cfg = default_settings();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_register_access();
    test_quick_release();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    test_output_holdoff();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("with input gaps, output stalls and a %0d-cycle output hold-off",
             HOLDOFF_CYCLES);
    if (fail_count == 0) begin
      $display("** classifier_status_lock_filter_core: PASSED **");
    end else begin
      $display("** classifier_status_lock_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
